// ===== rtl/psc_pkg.sv =====
// Shared types and constants of the prefix stack calculator.
package psc_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int DIV_STEPS   = DATA_W;
  localparam int DSTEP_W     = $clog2(DIV_STEPS);

  localparam logic [DATA_W-1:0] FX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] FX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic signed [DATA_W-1:0] fx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [PTR_W-1:0]         ptr_t;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_APPLY = 2'd1,
    ACT_END   = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_DONE     = 3'd1,
    ST_FEW      = 3'd2,
    ST_DIVZERO  = 3'd3,
    ST_BADOP    = 3'd4,
    ST_FULL     = 3'd5,
    ST_BADCOUNT = 3'd6,
    ST_IGNORED  = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_BUSY,
    S_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    AL_IDLE,
    AL_MUL,
    AL_DIV
  } alu_state_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

endpackage

// ===== rtl/psc_if.sv =====
// Valid/ready channel interfaces for token and result words.
interface psc_tok_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic signed [31:0] operand_value;
  logic [2:0]        op_code;

  modport source (output valid, action, operand_value, op_code, input ready);
  modport sink   (input valid, action, operand_value, op_code, output ready);
endinterface

interface psc_res_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] result_value;
  logic [2:0]        status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

// ===== rtl/prefix_stack_calculator.sv =====
// Top level: prefix expression evaluator with operand stack and sequencer.
//
//   channel | role   | fields
//   --------+--------+---------------------------------------
//   tok     | sink   | action, operand_value, op_code
//   res     | source | result_value, status
//
// Each token word yields one result word. A token is accepted only in idle,
// so the next one waits until the last has gone through decode, the ALU if
// needed (divide runs the 32-step radix-2 divider in psc_alu) and output.
// Reset clears stack count and error flag; stack entries are not cleared.
// A result waits in the output register while the next token is accepted;
// a second result stalls the sequencer until res is taken.
module prefix_stack_calculator (
  input logic     clk,
  input logic     rst,
  psc_tok_if.sink tok,
  psc_res_if.source res
);
  import psc_pkg::*;

  seq_state_t state, state_next;

  fx_t  stack_mem [STACK_DEPTH];
  fx_t  top_q, next_q;
  cnt_t count, count_next;
  logic err, err_next;

  action_t t_action;
  fx_t     t_value;
  op_t     t_op;

  status_t r_status, r_status_next;
  fx_t     r_value, r_value_next;

  logic    mem_we;
  ptr_t    mem_waddr;
  fx_t     mem_wdata;
  ptr_t    rd_top, rd_next;

  alu_req_t alu_req;
  logic     alu_done;
  fx_t      alu_result;

  logic    out_valid;
  fx_t     out_value;
  status_t out_status;
  logic    load_out;

  assign tok.ready        = (state == S_IDLE);
  assign res.valid        = out_valid;
  assign res.result_value = out_value;
  assign res.status       = out_status;

  always_comb begin
    rd_top  = ptr_t'(count - cnt_t'(1));
    rd_next = ptr_t'(count - cnt_t'(2));
  end

  always_ff @(posedge clk) begin
    if (mem_we) stack_mem[mem_waddr] <= mem_wdata;
    top_q  <= stack_mem[rd_top];
    next_q <= stack_mem[rd_next];
  end

  psc_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .a      (top_q),
    .b      (next_q),
    .done   (alu_done),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    err_next      = err;
    r_status_next = r_status;
    r_value_next  = r_value;
    mem_we        = 1'b0;
    mem_waddr     = ptr_t'(count);
    mem_wdata     = t_value;
    alu_req       = '{start: 1'b0, op: t_op};
    load_out      = 1'b0;

    case (state)
      S_IDLE: begin
        if (tok.valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next    = S_OUT;
        r_status_next = ST_IGNORED;
        r_value_next  = '0;
        case (t_action)
          ACT_PUSH: begin
            if (!err) begin
              if (count >= cnt_t'(STACK_DEPTH)) begin
                r_status_next = ST_FULL;
                err_next      = 1'b1;
              end else begin
                mem_we        = 1'b1;
                count_next    = count + cnt_t'(1);
                r_status_next = ST_ACCEPTED;
              end
            end
          end
          ACT_APPLY: begin
            if (!err) begin
              if (count < cnt_t'(2)) begin
                r_status_next = ST_FEW;
                err_next      = 1'b1;
              end else begin
                // both operands are consumed, even on an error
                count_next = count - cnt_t'(2);
                case (t_op)
                  OP_ADD, OP_SUB, OP_MUL: begin
                    alu_req.start = 1'b1;
                    state_next    = S_BUSY;
                  end
                  OP_DIV: begin
                    if (next_q == '0) begin
                      r_status_next = ST_DIVZERO;
                      err_next      = 1'b1;
                    end else begin
                      alu_req.start = 1'b1;
                      state_next    = S_BUSY;
                    end
                  end
                  default: begin
                    r_status_next = ST_BADOP;
                    err_next      = 1'b1;
                  end
                endcase
              end
            end
          end
          ACT_END: begin
            if (err) begin
              r_status_next = ST_IGNORED;
            end else if (count != cnt_t'(1)) begin
              r_status_next = ST_BADCOUNT;
            end else begin
              r_status_next = ST_DONE;
              r_value_next  = top_q;
            end
            count_next = '0;
            err_next   = 1'b0;
          end
          default: r_status_next = ST_IGNORED;
        endcase
      end
      S_BUSY: begin
        if (alu_done) begin
          mem_we        = 1'b1;
          mem_wdata     = alu_result;
          count_next    = count + cnt_t'(1);
          r_status_next = ST_ACCEPTED;
          r_value_next  = '0;
          state_next    = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || res.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      err       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      err   <= err_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    r_status <= r_status_next;
    r_value  <= r_value_next;
    if (tok.valid && tok.ready) begin
      t_action <= action_t'(tok.action);
      t_value  <= tok.operand_value;
      t_op     <= op_t'(tok.op_code);
    end
    if (load_out) begin
      out_value  <= r_value;
      out_status <= r_status;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (tok.valid && tok.ready) |=> state == S_DECODE)
    else $error("accepted word not decoded next");

  a_alu_done_busy: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> state == S_BUSY)
    else $error("alu result with no pending operator");

  a_value_only_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_DONE) |-> out_value == '0)
    else $error("nonzero value on a non-final result");

  a_load_after_out: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid && state == S_IDLE)
    else $error("result load lost");
`endif

endmodule

// ===== rtl/psc_alu.sv =====
// Shared Q16.16 arithmetic unit: saturating add/sub, multiply, radix-2 divide.
module psc_alu (
  input  logic             clk,
  input  logic             rst,
  input  psc_pkg::alu_req_t req,
  input  psc_pkg::fx_t     a,
  input  psc_pkg::fx_t     b,
  output logic             done,
  output psc_pkg::fx_t     result
);
  import psc_pkg::*;

  alu_state_t state, state_next;

  logic signed [2*DATA_W-1:0] prod;
  logic [DATA_W-1:0]          rem;
  logic [DATA_W-1:0]          dvsr;
  logic [DATA_W-1:0]          shreg;
  logic                       neg;
  logic                       ovf;
  logic [DSTEP_W-1:0]         step;

  logic [DATA_W-1:0] abs_a, abs_b;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] sum_sat;
  logic [DATA_W:0]   trial;
  logic              ge;
  logic [DATA_W-1:0] rem_next;
  logic [DATA_W-1:0] q_final;
  logic [DATA_W-1:0] div_sat;
  logic [DATA_W-1:0] mul_sat;
  logic [DATA_W-FRAC_W:0] prod_hi;

  always_comb begin
    abs_a = a[DATA_W-1] ? (DATA_W'(0) - a) : a;
    abs_b = b[DATA_W-1] ? (DATA_W'(0) - b) : b;

    if (req.op == OP_SUB) begin
      sum = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    end else begin
      sum = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    end
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      sum_sat = sum[DATA_W] ? FX_MIN : FX_MAX;
    end else begin
      sum_sat = sum[DATA_W-1:0];
    end

    // product >>> 16 is floor; saturate when the top bits are not a sign run
    prod_hi = prod[2*DATA_W-1:DATA_W+FRAC_W-1];
    if (prod_hi == '0 || prod_hi == '1) begin
      mul_sat = prod[DATA_W+FRAC_W-1:FRAC_W];
    end else begin
      mul_sat = prod[2*DATA_W-1] ? FX_MIN : FX_MAX;
    end

    trial    = {rem, shreg[DATA_W-1]};
    ge       = trial >= {1'b0, dvsr};
    rem_next = ge ? DATA_W'(trial - {1'b0, dvsr}) : trial[DATA_W-1:0];
    q_final  = {shreg[DATA_W-2:0], ge};

    if (neg) begin
      div_sat = (ovf || q_final > FX_MIN) ? FX_MIN : (DATA_W'(0) - q_final);
    end else begin
      div_sat = (ovf || q_final[DATA_W-1]) ? FX_MAX : q_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      AL_IDLE: begin
        if (req.start && req.op == OP_MUL) state_next = AL_MUL;
        if (req.start && req.op == OP_DIV) state_next = AL_DIV;
      end
      AL_MUL:  state_next = AL_IDLE;
      AL_DIV: begin
        if (step == DSTEP_W'(DIV_STEPS - 1)) state_next = AL_IDLE;
      end
      default: state_next = AL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == AL_IDLE && req.start &&
               (req.op == OP_ADD || req.op == OP_SUB)) ||
              (state == AL_MUL) ||
              (state == AL_DIV && step == DSTEP_W'(DIV_STEPS - 1));
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      AL_IDLE: begin
        if (req.start) begin
          result <= sum_sat;
          prod   <= a * b;
          neg    <= a[DATA_W-1] ^ b[DATA_W-1];
          // quotient of 2^32 or more: saturate whatever the steps give
          ovf    <= {{FRAC_W{1'b0}}, abs_a} >= {abs_b, {FRAC_W{1'b0}}};
          rem    <= {{FRAC_W{1'b0}}, abs_a[DATA_W-1:FRAC_W]};
          shreg  <= {abs_a[FRAC_W-1:0], {(DATA_W-FRAC_W){1'b0}}};
          dvsr   <= abs_b;
          step   <= '0;
        end
      end
      AL_MUL: result <= mul_sat;
      AL_DIV: begin
        rem   <= rem_next;
        shreg <= q_final;
        step  <= step + 1'b1;
        if (step == DSTEP_W'(DIV_STEPS - 1)) result <= div_sat;
      end
      default: ;
    endcase
  end

endmodule

// ===== verif/prefix_stack_calculator_checker.sv =====
// Checker for the prefix stack calculator: predicts each result word and compares.
module prefix_stack_calculator_checker (
  input  logic clk,
  input  logic rst,
  psc_tok_if   tok,
  psc_res_if   res,
  output int   fail_count,
  output int   words_owed
);
  import psc_pkg::*;

  typedef struct packed {
    fx_t     value;
    status_t status;
  } answer_t;

  localparam longint SAT_HI = (longint'(1) <<< (DATA_W - 1)) - 1;
  localparam longint SAT_LO = -(longint'(1) <<< (DATA_W - 1));

  fx_t     stack_mem [STACK_DEPTH];
  int      depth;
  logic    err_flag;
  answer_t answer_q [$];
  int      fails;

  function automatic fx_t clamp_fx(longint v);
    if (v > SAT_HI) return fx_t'(FX_MAX);
    if (v < SAT_LO) return fx_t'(FX_MIN);
    return fx_t'(v);
  endfunction

  function automatic answer_t evaluate_token(logic [1:0] act, fx_t val, logic [2:0] op);
    answer_t ans;
    fx_t     lhs;
    fx_t     rhs;
    longint  wide;
    ans.value  = '0;
    ans.status = ST_IGNORED;
    wide       = 0;
    case (act)
      ACT_PUSH: begin
        if (!err_flag) begin
          if (depth >= STACK_DEPTH) begin
            ans.status = ST_FULL;
            err_flag   = 1'b1;
          end else begin
            stack_mem[depth] = val;
            depth++;
            ans.status = ST_ACCEPTED;
          end
        end
      end
      ACT_APPLY: begin
        if (!err_flag) begin
          if (depth < 2) begin
            ans.status = ST_FEW;
            err_flag   = 1'b1;
          end else begin
            // top of stack is the left operand
            lhs        = stack_mem[depth-1];
            rhs        = stack_mem[depth-2];
            depth      = depth - 2;
            ans.status = ST_ACCEPTED;
            case (op)
              OP_ADD: wide = longint'(lhs) + longint'(rhs);
              OP_SUB: wide = longint'(lhs) - longint'(rhs);
              OP_MUL: wide = (longint'(lhs) * longint'(rhs)) >>> FRAC_W;  // floor
              OP_DIV: begin
                if (rhs == 0) ans.status = ST_DIVZERO;
                else wide = (longint'(lhs) <<< FRAC_W) / longint'(rhs);  // truncates
              end
              default: ans.status = ST_BADOP;
            endcase
            if (ans.status == ST_ACCEPTED) begin
              stack_mem[depth] = clamp_fx(wide);
              depth++;
            end else begin
              err_flag = 1'b1;
            end
          end
        end
      end
      ACT_END: begin
        if (err_flag) begin
          ans.status = ST_IGNORED;
        end else if (depth != 1) begin
          ans.status = ST_BADCOUNT;
        end else begin
          ans.status = ST_DONE;
          ans.value  = stack_mem[0];
        end
        depth    = 0;
        err_flag = 1'b0;
      end
      default: ans.status = ST_IGNORED;
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin : watch
    answer_t want;
    if (rst) begin
      depth    = 0;
      err_flag = 1'b0;
      answer_q.delete();
    end else begin
      // retire the result word first; a token accepted on this edge is newer
      if (res.valid && res.ready) begin
        if (answer_q.size() == 0) begin
          $error("unexpected result word: status %0d, result_value %0d",
                 res.status, res.result_value);
          fails++;
        end else begin
          want = answer_q.pop_front();
          if (res.result_value !== want.value) begin
            $error("result_value: expected %0d, got %0d", want.value, res.result_value);
            fails++;
          end
          if (res.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res.status);
            fails++;
          end
        end
      end
      if (tok.valid && tok.ready)
        answer_q.push_back(evaluate_token(tok.action, tok.operand_value, tok.op_code));
    end
    fail_count <= fails;
    words_owed <= answer_q.size();
  end

endmodule

// ===== verif/prefix_stack_calculator_test.sv =====
// Testbench top: token stimulus, result back-pressure and the final verdict.
module prefix_stack_calculator_test;
  import psc_pkg::*;

  localparam int         CYCLE_LIMIT = 1000000;
  localparam int         ITEM_TARGET = 1850;
  localparam int         CALM_AFTER  = 1600;
  localparam int         DRAIN_WAIT  = 50;
  localparam fx_t        ONE         = 32'sh0001_0000;
  localparam logic [2:0] OP_UNKNOWN  = 3'd4;

  logic clk;
  logic rst;
  int   fail_total;
  int   words_owed;
  int   sent_items;
  bit   gaps_on;
  bit   stalls_on;

  psc_tok_if tok_ch ();
  psc_res_if res_ch ();

  prefix_stack_calculator u_dut (
    .clk (clk),
    .rst (rst),
    .tok (tok_ch),
    .res (res_ch)
  );

  prefix_stack_calculator_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .tok        (tok_ch),
    .res        (res_ch),
    .fail_count (fail_total),
    .words_owed (words_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: ready drops at random, in bursts, while stalls are on
  initial begin : res_pacing
    int hold_left;
    hold_left    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        res_ch.ready <= 1'b0;
        hold_left = $urandom_range(0, 2);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic fx_t pick_value();
    case ($urandom_range(0, 9))
      0: return fx_t'(FX_MAX);
      1: return fx_t'(FX_MIN);
      2: return '0;
      3: return fx_t'($urandom);
      4: return ($urandom_range(0, 1) != 0) ? fx_t'(1) : fx_t'(-1);
      default: return fx_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  // valid stays high from one word to the next unless a gap is inserted
  task automatic send_token(logic [1:0] act, fx_t val, logic [2:0] op);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      tok_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    tok_ch.valid         <= 1'b1;
    tok_ch.action        <= act;
    tok_ch.operand_value <= val;
    tok_ch.op_code       <= op;
    do @(posedge clk); while (!tok_ch.ready);
    sent_items++;
  endtask

  // expression: pushes and operators interleaved, depth kept legal, now and then an unknown operator code
  task automatic run_expression(int leaves);
    int held;
    int left_to_push;
    logic [2:0] op;
    held         = 0;
    left_to_push = leaves;
    while (left_to_push > 0 || held > 1) begin
      if (held < 2 || (left_to_push > 0 && held < STACK_DEPTH && $urandom_range(0, 2) != 0))
      begin
        send_token(ACT_PUSH, pick_value(), 3'($urandom_range(0, 7)));
        held++;
        left_to_push--;
      end else begin
        op = ($urandom_range(0, 29) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
        send_token(ACT_APPLY, fx_t'($urandom), op);
        held--;
      end
    end
    send_token(ACT_END, fx_t'($urandom), 3'($urandom_range(0, 7)));
  endtask

  initial begin : stimulus
    int pick;
    int n;
    rst                  = 1'b1;
    tok_ch.valid         = 1'b0;
    tok_ch.action        = ACT_PUSH;
    tok_ch.operand_value = '0;
    tok_ch.op_code       = OP_ADD;
    sent_items           = 0;
    gaps_on              = 1'b1;
    stalls_on            = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every operator, every error path but a full stack
    send_token(ACT_END, '0, OP_ADD);                 // empty stack
    send_token(ACT_PUSH, fx_t'(FX_MIN), OP_ADD);
    send_token(ACT_PUSH, ONE, OP_ADD);
    send_token(ACT_APPLY, '0, OP_SUB);               // saturates high
    send_token(ACT_PUSH, fx_t'(-1), OP_ADD);
    send_token(ACT_APPLY, '0, OP_MUL);               // negative product rounds down
    send_token(ACT_PUSH, fx_t'(1), OP_ADD);
    send_token(ACT_APPLY, '0, OP_DIV);
    send_token(ACT_PUSH, fx_t'(FX_MAX), OP_ADD);
    send_token(ACT_APPLY, '0, OP_ADD);
    send_token(ACT_END, '0, OP_ADD);
    send_token(ACT_PUSH, fx_t'(1), OP_ADD);
    send_token(ACT_PUSH, fx_t'(FX_MAX), OP_ADD);
    send_token(ACT_APPLY, '0, OP_DIV);               // quotient saturates
    send_token(ACT_END, '0, OP_ADD);
    send_token(ACT_PUSH, '0, OP_ADD);
    send_token(ACT_PUSH, fx_t'(FX_MIN), OP_ADD);
    send_token(ACT_APPLY, '0, OP_DIV);               // divide by zero
    send_token(ACT_PUSH, ONE, OP_ADD);               // dropped while in error
    send_token(ACT_END, '0, OP_ADD);
    send_token(ACT_APPLY, '0, OP_ADD);               // too few operands
    send_token(ACT_END, '0, OP_ADD);
    send_token(ACT_PUSH, ONE, OP_ADD);
    send_token(ACT_PUSH, ONE, OP_ADD);
    send_token(ACT_APPLY, '0, OP_UNKNOWN);
    send_token(ACT_END, '0, OP_ADD);
    send_token(ACT_PUSH, ONE, OP_ADD);
    send_token(ACT_PUSH, ONE, OP_ADD);
    send_token(ACT_END, '0, OP_ADD);                 // two values left

    while (sent_items < ITEM_TARGET) begin
      if (sent_items > CALM_AFTER) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end else begin
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        run_expression(($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6));
      end else if (pick == 15) begin
        // overrun the stack
        n = $urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 2);
        repeat (n) send_token(ACT_PUSH, pick_value(), 3'($urandom_range(0, 7)));
        send_token(ACT_END, '0, OP_ADD);
      end else begin
        // noise: arbitrary tokens, then an end mark
        n = $urandom_range(1, 8);
        repeat (n) send_token(2'($urandom_range(0, 2)), pick_value(), 3'($urandom_range(0, 7)));
        send_token(ACT_END, pick_value(), 3'($urandom_range(0, 7)));
      end
    end
    tok_ch.valid <= 1'b0;

    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_total == 0 && words_owed == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
